FILE: rtl/core/lpg_pkg.sv
// Package for the line pixel generator.
// Holds the transaction mode code shared by the channel interface and the core modules.
package lpg_pkg;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_ADVANCE = 1'b1
    } mode_t;

endpackage

FILE: rtl/core/lpg_if.sv
// Channel interfaces of the line pixel generator: command input and pixel output.
// Depends on lpg_pkg for the mode type.
interface lpg_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    lpg_pkg::mode_t               mode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, mode, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, mode, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface lpg_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, last_pixel,
        output ready
    );
endinterface

FILE: rtl/core/lpg_setup.sv
// Line setup logic: picks the major axis, orders the endpoints and forms the initial error.
// Purely combinational; used by lpg_walker on a load transaction.
module lpg_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         x_is_major,
    output logic signed [COORD_BITS-1:0] major_start,
    output logic signed [COORD_BITS-1:0] minor_start,
    output logic signed [COORD_BITS-1:0] major_stop,
    output logic        [COORD_BITS:0]   major_delta,
    output logic        [COORD_BITS:0]   minor_delta,
    output logic                         minor_step_down,
    output logic signed [COORD_BITS+3:0] error_init
);
    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [DW-1:0] abs_dx;
    logic        [DW-1:0] abs_dy;
    logic signed [DW-1:0] d_major;
    logic signed [DW-1:0] d_minor;
    logic                 swap;

    always_comb
    begin
        dx     = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
        dy     = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
        abs_dx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        abs_dy = dy[DW-1] ? DW'(-dy) : DW'(dy);

        x_is_major = (abs_dy < abs_dx);
        d_major    = x_is_major ? dx : dy;
        d_minor    = x_is_major ? dy : dx;
        swap       = d_major[DW-1];

        if (x_is_major)
        begin
            major_start = swap ? end_x : start_x;
            major_stop  = swap ? start_x : end_x;
            minor_start = swap ? end_y : start_y;
            major_delta = abs_dx;
            minor_delta = abs_dy;
        end
        else
        begin
            major_start = swap ? end_y : start_y;
            major_stop  = swap ? start_y : end_y;
            minor_start = swap ? end_x : start_x;
            major_delta = abs_dy;
            minor_delta = abs_dx;
        end

        minor_step_down = (d_minor != '0) && (d_minor[DW-1] ^ swap);
        error_init      = $signed({2'b00, minor_delta, 1'b0}) - $signed({3'b000, major_delta});
    end
endmodule

FILE: rtl/core/lpg_walker.sv
// Line state registers, Bresenham step logic and the pixel result register.
// Depends on lpg_pkg, lpg_if (pixel channel) and lpg_setup.
module lpg_walker #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  lpg_pkg::mode_t               mode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         can_take,
    lpg_pix_if.source                    pixel
);
    import lpg_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 4;

    logic                 line_active_reg,     line_active_next;
    logic                 x_is_major_reg,      x_is_major_next;
    logic signed [CW-1:0] major_pos_reg,       major_pos_next;
    logic signed [CW-1:0] minor_pos_reg,       minor_pos_next;
    logic signed [CW-1:0] major_stop_reg,      major_stop_next;
    logic        [DW-1:0] major_delta_reg,     major_delta_next;
    logic        [DW-1:0] minor_delta_reg,     minor_delta_next;
    logic                 minor_step_down_reg, minor_step_down_next;
    logic signed [EW-1:0] error_term_reg,      error_term_next;

    logic                 out_valid_reg,       out_valid_next;
    logic signed [CW-1:0] pixel_x_reg,         pixel_x_next;
    logic signed [CW-1:0] pixel_y_reg,         pixel_y_next;
    logic                 last_pixel_reg,      last_pixel_next;

    logic                 su_x_is_major;
    logic signed [CW-1:0] su_major_start;
    logic signed [CW-1:0] su_minor_start;
    logic signed [CW-1:0] su_major_stop;
    logic        [DW-1:0] su_major_delta;
    logic        [DW-1:0] su_minor_delta;
    logic                 su_minor_step_down;
    logic signed [EW-1:0] su_error_init;

    logic                 load;
    logic                 advance;
    logic                 at_stop;
    logic signed [DW:0]   delta_diff;
    logic signed [EW-1:0] gain_diag;
    logic signed [EW-1:0] gain_straight;
    logic                 error_pos;

    lpg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x         (start_x),
        .start_y         (start_y),
        .end_x           (end_x),
        .end_y           (end_y),
        .x_is_major      (su_x_is_major),
        .major_start     (su_major_start),
        .minor_start     (su_minor_start),
        .major_stop      (su_major_stop),
        .major_delta     (su_major_delta),
        .minor_delta     (su_minor_delta),
        .minor_step_down (su_minor_step_down),
        .error_init      (su_error_init)
    );

    assign can_take = !out_valid_reg || pixel.ready;

    always_comb
    begin
        load    = step_en && (mode == MODE_LOAD);
        advance = step_en && (mode == MODE_ADVANCE) && line_active_reg;
        at_stop = (major_pos_reg == major_stop_reg);

        delta_diff    = $signed({1'b0, minor_delta_reg}) - $signed({1'b0, major_delta_reg});
        gain_diag     = $signed({delta_diff[DW], delta_diff, 1'b0});
        gain_straight = $signed({2'b00, minor_delta_reg, 1'b0});
        error_pos     = !error_term_reg[EW-1] && (error_term_reg != '0);

        line_active_next     = line_active_reg;
        x_is_major_next      = x_is_major_reg;
        major_pos_next       = major_pos_reg;
        minor_pos_next       = minor_pos_reg;
        major_stop_next      = major_stop_reg;
        major_delta_next     = major_delta_reg;
        minor_delta_next     = minor_delta_reg;
        minor_step_down_next = minor_step_down_reg;
        error_term_next      = error_term_reg;

        if (load)
        begin
            line_active_next     = 1'b1;
            x_is_major_next      = su_x_is_major;
            major_pos_next       = su_major_start;
            minor_pos_next       = su_minor_start;
            major_stop_next      = su_major_stop;
            major_delta_next     = su_major_delta;
            minor_delta_next     = su_minor_delta;
            minor_step_down_next = su_minor_step_down;
            error_term_next      = su_error_init;
        end
        else if (advance)
        begin
            if (at_stop)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                if (error_pos)
                begin
                    minor_pos_next  = minor_step_down_reg ? CW'(minor_pos_reg - 1'b1)
                                                          : CW'(minor_pos_reg + 1'b1);
                    error_term_next = EW'(error_term_reg + gain_diag);
                end
                else
                begin
                    error_term_next = EW'(error_term_reg + gain_straight);
                end
                major_pos_next = CW'(major_pos_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !pixel.ready;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        last_pixel_next = last_pixel_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            pixel_x_next    = x_is_major_reg ? major_pos_reg : minor_pos_reg;
            pixel_y_next    = x_is_major_reg ? minor_pos_reg : major_pos_reg;
            last_pixel_next = at_stop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg     <= 1'b0;
            x_is_major_reg      <= 1'b0;
            major_pos_reg       <= '0;
            minor_pos_reg       <= '0;
            major_stop_reg      <= '0;
            major_delta_reg     <= '0;
            minor_delta_reg     <= '0;
            minor_step_down_reg <= 1'b0;
            error_term_reg      <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            line_active_reg     <= line_active_next;
            x_is_major_reg      <= x_is_major_next;
            major_pos_reg       <= major_pos_next;
            minor_pos_reg       <= minor_pos_next;
            major_stop_reg      <= major_stop_next;
            major_delta_reg     <= major_delta_next;
            minor_delta_reg     <= minor_delta_next;
            minor_step_down_reg <= minor_step_down_next;
            error_term_reg      <= error_term_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg    <= pixel_x_next;
        pixel_y_reg    <= pixel_y_next;
        last_pixel_reg <= last_pixel_next;
    end

    assign pixel.valid      = out_valid_reg;
    assign pixel.pixel_x    = pixel_x_reg;
    assign pixel.pixel_y    = pixel_y_reg;
    assign pixel.last_pixel = last_pixel_reg;

    // The minor extent never exceeds the major extent of the loaded line.
    a_delta_order : assert property (@(posedge clk) disable iff (!rst_n)
        minor_delta_reg <= major_delta_reg)
        else $error("minor delta exceeds major delta");

    // While a line is active the walk has not passed its final major coordinate.
    a_within_line : assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (major_pos_reg <= major_stop_reg))
        else $error("major position passed the line end");

    // Emitting the final pixel ends the line and flags the result.
    a_last_ends_line : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && at_stop) |=> (!line_active_reg && out_valid_reg && last_pixel_reg))
        else $error("final pixel did not end the line");

    // A load transaction starts a line and does not produce a pixel of its own.
    a_load_starts : assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (line_active_reg && (out_valid_reg == ($past(out_valid_reg)
                                                         && !$past(pixel.ready)))))
        else $error("load transaction misbehaved");
endmodule

FILE: rtl/core/line_pixel_generator.sv
// Top level of the line pixel generator: command input register and core instance.
// Depends on lpg_pkg, lpg_if and lpg_walker.
//
//  Channel | Dir | Payload                                   | Transfer
//  cmd     | in  | mode, start_x, start_y, end_x, end_y      | valid && ready
//  pixel   | out | pixel_x, pixel_y, last_pixel              | valid && ready
//
// One command transaction is taken per cycle while cmd.ready is high; an advance
// transaction passes through the input register and then the pixel register before its
// pixel is valid. The line state is updated in a single pass, so consecutive advances
// sustain one pixel per clock while the pixel output is not stalled. A stalled pixel
// output holds the command register, and cmd.ready drops only while that register is
// full and cannot move. rst_n clears the line and both valid flags.
module line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic    clk,
    input  logic    rst_n,
    lpg_cmd_if.sink cmd,
    lpg_pix_if.source pixel
);
    import lpg_pkg::*;

    localparam int CW = COORD_BITS;

    logic                 cmd_valid_reg, cmd_valid_next;
    mode_t                mode_reg;
    logic signed [CW-1:0] start_x_reg;
    logic signed [CW-1:0] start_y_reg;
    logic signed [CW-1:0] end_x_reg;
    logic signed [CW-1:0] end_y_reg;

    logic can_take;
    logic step_en;
    logic cmd_fire;

    assign step_en   = cmd_valid_reg && can_take;
    assign cmd.ready = !cmd_valid_reg || can_take;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_fire)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            mode_reg    <= cmd.mode;
            start_x_reg <= cmd.start_x;
            start_y_reg <= cmd.start_y;
            end_x_reg   <= cmd.end_x;
            end_y_reg   <= cmd.end_y;
        end
    end

    lpg_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .mode     (mode_reg),
        .start_x  (start_x_reg),
        .start_y  (start_y_reg),
        .end_x    (end_x_reg),
        .end_y    (end_y_reg),
        .can_take (can_take),
        .pixel    (pixel)
    );

    // The command register only refuses new transactions while it holds one it cannot pass on.
    a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (cmd_valid_reg && !can_take))
        else $error("command ready dropped without a blocked transaction");

    // A held command that cannot move stays in the register.
    a_cmd_held : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && !can_take) |=> cmd_valid_reg)
        else $error("blocked command transaction was lost");

    // A command moving on while none arrives leaves the register empty.
    a_cmd_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !cmd_fire) |=> !cmd_valid_reg)
        else $error("command register did not drain");
endmodule
